// ===== rtl/ucnc_pkg.sv =====
`timescale 1ns / 1ps

package ucnc_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned ValueW    = 36;
  localparam int unsigned ValueOutW = 42;
  localparam int unsigned CountW    = 3;
  localparam int unsigned GroupW    = 6;

  // command codes
  localparam logic CmdDecode = 1'b0;
  localparam logic CmdEncode = 1'b1;

  // result kinds
  localparam logic KindValue = 1'b0;
  localparam logic KindByte  = 1'b1;

  typedef struct packed {
    logic                 vld;
    logic [ValueOutW-1:0] value;
  } dec_res_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } enc_res_t;

endpackage

// ===== rtl/ucnc_decoder.sv =====
`timescale 1ns / 1ps

module ucnc_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [ucnc_pkg::ByteW-1:0] byte_i,
  output ucnc_pkg::dec_res_t         res_o
);
  import ucnc_pkg::*;

  logic [CountW-1:0]    pending_q, pending_d;
  logic [ValueOutW-1:0] acc_q, acc_d;
  logic [3:0]           ones;
  logic [ByteW-1:0]     lead_mask;

  always_comb begin
    casez (byte_i)
      8'b0???????: ones = 4'd0;
      8'b10??????: ones = 4'd1;
      8'b110?????: ones = 4'd2;
      8'b1110????: ones = 4'd3;
      8'b11110???: ones = 4'd4;
      8'b111110??: ones = 4'd5;
      8'b1111110?: ones = 4'd6;
      8'b11111110: ones = 4'd7;
      default:     ones = 4'd8;
    endcase
  end

  // lead keeps its low 7-n bits
  assign lead_mask = 8'h7F >> ones;

  always_comb begin
    pending_d = pending_q;
    acc_d     = acc_q;
    res_o.vld   = 1'b0;
    res_o.value = '0;
    if (step_i) begin
      if (pending_q != '0) begin
        acc_d     = {acc_q[ValueOutW-GroupW-1:0], byte_i[GroupW-1:0]};
        pending_d = pending_q - 3'd1;
        if (pending_q == 3'd1) begin
          res_o.vld   = 1'b1;
          res_o.value = acc_d;
        end
      end else if (ones < 4'd2) begin
        res_o.vld   = 1'b1;
        res_o.value = {{(ValueOutW-ByteW){1'b0}}, byte_i};
      end else begin
        if (ones >= 4'd7) begin
          acc_d = '0;
        end else begin
          acc_d = {{(ValueOutW-ByteW){1'b0}}, byte_i & lead_mask};
        end
        pending_d = CountW'(ones - 4'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      acc_q     <= '0;
    end else begin
      pending_q <= pending_d;
      acc_q     <= acc_d;
    end
  end

  a_result_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.vld |=> pending_q == '0)
    else $error("pending count not cleared after decoded value");

  a_result_only_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(pending_q) && $stable(acc_q))
    else $error("decode state moved without a step");

endmodule

// ===== rtl/ucnc_encoder.sv =====
`timescale 1ns / 1ps

module ucnc_encoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [ucnc_pkg::ValueW-1:0] value_i,
  input  logic [ucnc_pkg::CountW-1:0] num_bytes_i,
  output ucnc_pkg::enc_res_t          res_o
);
  import ucnc_pkg::*;

  logic [CountW-1:0]    idx_q, idx_d;
  logic [CountW-1:0]    nb_eff;
  logic [CountW-1:0]    grp_sel;
  logic [ValueOutW-1:0] padded;
  logic [GroupW-1:0]    grp;
  logic [ByteW-1:0]     lead_mask;
  logic [ByteW-1:0]     lead_prefix;

  // a byte count of zero codes like one
  assign nb_eff  = (num_bytes_i == '0) ? 3'd1 : num_bytes_i;
  // six-bit group for this byte, most significant first; group six is all zero
  assign grp_sel = nb_eff - 3'd1 - idx_q;
  assign padded  = {{(ValueOutW-ValueW){1'b0}}, value_i};
  assign grp     = padded[grp_sel*GroupW +: GroupW];

  assign lead_mask   = 8'h7F >> nb_eff;
  assign lead_prefix = ~(8'hFF >> nb_eff);

  always_comb begin
    if (nb_eff == 3'd1) begin
      res_o.data = {1'b0, value_i[6:0]};
    end else if (idx_q == '0) begin
      res_o.data = lead_prefix | ({2'b00, grp} & lead_mask);
    end else begin
      res_o.data = {2'b10, grp};
    end
    res_o.last = (idx_q == nb_eff - 3'd1);
  end

  always_comb begin
    idx_d = idx_q;
    if (step_i) begin
      idx_d = res_o.last ? '0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != '0 |-> idx_q < nb_eff)
    else $error("byte index beyond byte count");

  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.last |=> idx_q == '0)
    else $error("byte index not cleared after final byte");

endmodule

// ===== rtl/utf8_coded_number_codec_core.sv =====
`timescale 1ns / 1ps

// Coded frame number codec. A decode item (cmd 0) carries one coded byte and
// gives at most one result: a value result once the last byte of a number has
// arrived, or at once for a plain byte or a stray 0x80..0xBF lead. An encode
// item (cmd 1) gives num_bytes byte results (one for a count of zero), lead
// first. Items enter an input register and are worked into the output register
// combinationally, so decode runs at one byte per cycle with no bubbles while
// the receiver does not stall. An encode item holds the input register until
// its last result byte enters the output register, and longer while the
// receiver stalls. Results are taken from a registered output; a new item is
// taken while the previous result waits only if the input register is empty.
module utf8_coded_number_codec_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic [ucnc_pkg::ByteW-1:0]     byte_in_i,
  input  logic [ucnc_pkg::ValueW-1:0]    value_i,
  input  logic [ucnc_pkg::CountW-1:0]    num_bytes_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           kind_o,
  output logic [ucnc_pkg::ByteW-1:0]     byte_out_o,
  output logic [ucnc_pkg::ValueOutW-1:0] value_out_o,
  output logic                           last_o
);
  import ucnc_pkg::*;

  logic                 in_vld_q, in_vld_d;
  logic                 cmd_q;
  logic [ByteW-1:0]     byte_q;
  logic [ValueW-1:0]    value_q;
  logic [CountW-1:0]    nb_q;

  logic                 out_vld_q, out_vld_d;
  logic                 kind_q;
  logic [ByteW-1:0]     obyte_q;
  logic [ValueOutW-1:0] ovalue_q;
  logic                 last_q;

  logic                 adv;
  logic                 dec_step;
  logic                 enc_step;
  logic                 in_consume;
  logic                 in_xfer;
  dec_res_t             dec_res;
  enc_res_t             enc_res;

  // output slot is free or being emptied this cycle
  assign adv        = !out_vld_q || out_ready_i;
  assign dec_step   = in_vld_q && (cmd_q == CmdDecode) && adv;
  assign enc_step   = in_vld_q && (cmd_q == CmdEncode) && adv;
  assign in_consume = dec_step || (enc_step && enc_res.last);
  assign in_ready_o = !in_vld_q || in_consume;
  assign in_xfer    = in_valid_i && in_ready_o;

  ucnc_decoder u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (dec_step),
    .byte_i (byte_q),
    .res_o  (dec_res)
  );

  ucnc_encoder u_enc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (enc_step),
    .value_i     (value_q),
    .num_bytes_i (nb_q),
    .res_o       (enc_res)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_xfer) begin
      in_vld_d = 1'b1;
    end else if (in_consume) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = (dec_step && dec_res.vld) || enc_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q   <= cmd_i;
      byte_q  <= byte_in_i;
      value_q <= value_i;
      nb_q    <= num_bytes_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enc_step) begin
      kind_q   <= KindByte;
      obyte_q  <= enc_res.data;
      ovalue_q <= '0;
      last_q   <= enc_res.last;
    end else if (dec_step && dec_res.vld) begin
      kind_q   <= KindValue;
      obyte_q  <= '0;
      ovalue_q <= dec_res.value;
      last_q   <= 1'b1;
    end
  end

  assign out_valid_o = out_vld_q;
  assign kind_o      = kind_q;
  assign byte_out_o  = obyte_q;
  assign value_out_o = ovalue_q;
  assign last_o      = last_q;

  a_value_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && kind_q == KindValue |-> last_q && obyte_q == '0)
    else $error("decoded value result malformed");

  a_partial_encode_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && kind_q == KindByte && !last_q |-> in_vld_q && cmd_q == CmdEncode)
    else $error("encode item released before its final byte");

  a_no_accept_mid_encode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enc_step && !enc_res.last |-> !in_ready_o)
    else $error("input taken while encode bytes remain");

endmodule
